### rtl/core/ffca_pkg.sv
// Shared types and constants for the first-fit cell allocator.
package ffca_pkg;

    localparam int CELLS_DEF   = 64;
    localparam int ID_BITS_DEF = 16;

    localparam int CNT_W    = 7;
    localparam int SIZE_W   = 8;
    localparam int EID_W    = 16;
    localparam int STATUS_W = 3;
    localparam int MAX_N    = (2 ** CNT_W) - 1;

    localparam logic [CNT_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ERASE  = 2'd1,
        OP_DEFRAG = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC   = 3'd0,
        ST_NULL    = 3'd1,
        ST_ERASED  = 3'd2,
        ST_ILLEGAL = 3'd3,
        ST_DEFRAG  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_ALLOC,
        CO_ERASE,
        CO_MARK,
        CO_SWAP
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_MARK,
        S_SWAP,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [SIZE_W-1:0] alloc_size;
        logic [EID_W-1:0]  erase_id;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [EID_W-1:0]    new_id;
    } t_out_item;

    // Broadcast command to every cell
    typedef struct packed {
        t_cell_op          op;
        logic [SIZE_W-1:0] size;
        logic [EID_W-1:0]  erase_id;
        logic [CNT_W-1:0]  n;
        logic [CNT_W-1:0]  mark_lo;
        logic [CNT_W-1:0]  mark_hi;
        logic              phase;
    } t_cell_cmd;

    // Scan token walking up the chain
    typedef struct packed {
        logic              valid;
        logic [SIZE_W-1:0] run;
        logic              found;
        logic [CNT_W-1:0]  end_idx;
        logic              hit;
    } t_tok;

endpackage

### rtl/core/ffca_cell.sv
// One storage cell of the allocator chain: owner id, scan token stage, neighbour swap.
module ffca_cell import ffca_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_cmd          i_cmd,
    input  logic [ID_BITS-1:0] i_mark_id,
    input  t_tok               i_tok,
    input  logic [ID_BITS-1:0] i_lo_owner,
    input  logic [ID_BITS-1:0] i_hi_owner,
    output t_tok               o_tok,
    output logic [ID_BITS-1:0] o_owner
);

    localparam int CW = (ID_BITS > EID_W) ? ID_BITS : EID_W;
    localparam bit IDX_OK = CELL_IDX < MAX_N;
    localparam bit HI_OK  = (CELL_IDX + 1) < MAX_N;
    localparam bit HAS_LO = CELL_IDX > 0;
    localparam logic [CNT_W-1:0] IDX    = CNT_W'(CELL_IDX);
    localparam logic [CNT_W:0]   IDX_P1 = (CNT_W + 1)'(CELL_IDX + 1);
    localparam logic             IDX_PAR = 1'(CELL_IDX % 2);

    logic [ID_BITS-1:0] r_owner;
    logic [ID_BITS-1:0] n_owner;
    t_tok               r_tok;
    t_tok               n_tok;
    logic               managed;
    logic               hi_managed;
    logic [SIZE_W-1:0]  run_n;
    logic [CW-1:0]      owner_ext;
    logic [CW-1:0]      id_ext;

    always_comb begin
        managed    = IDX_OK && (IDX < i_cmd.n);
        hi_managed = HI_OK && (IDX_P1 < {1'b0, i_cmd.n});
        run_n      = (r_owner == '0) ? (i_tok.run + SIZE_W'(1)) : '0;
        owner_ext  = CW'(r_owner);
        id_ext     = CW'(i_cmd.erase_id);
        n_tok      = i_tok;
        n_owner    = r_owner;
        unique case (i_cmd.op)
            CO_NONE: begin
            end
            CO_ALLOC: begin
                if (i_tok.valid && managed && !i_tok.found) begin
                    n_tok.run = run_n;
                    if (run_n == i_cmd.size) begin
                        n_tok.found   = 1'b1;
                        n_tok.end_idx = IDX;
                    end
                end
            end
            CO_ERASE: begin
                if (i_tok.valid && managed && (i_cmd.erase_id != '0)
                        && (owner_ext == id_ext)) begin
                    n_owner   = '0;
                    n_tok.hit = 1'b1;
                end
            end
            CO_MARK: begin
                if (managed && (IDX >= i_cmd.mark_lo) && (IDX <= i_cmd.mark_hi)) begin
                    n_owner = i_mark_id;
                end
            end
            CO_SWAP: begin
                // free cell below a used one: the two trade places
                if (IDX_PAR == i_cmd.phase) begin
                    if (hi_managed && (r_owner == '0) && (i_hi_owner != '0)) begin
                        n_owner = i_hi_owner;
                    end
                end else begin
                    if (HAS_LO && managed && (i_lo_owner == '0) && (r_owner != '0)) begin
                        n_owner = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
            r_tok   <= '0;
        end else begin
            r_owner <= n_owner;
            r_tok   <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_owner = r_owner;

endmodule

### rtl/core/first_fit_cell_allocator.sv
// First-fit contiguous cell allocator with compaction: control and cell chain.
//
//  channel   direction  handshake                   payload
//  in        to block   i_in_valid / o_in_stall      i_in  (op, alloc_size, erase_id)
//  out       from block o_out_valid / i_out_stall    o_out (status, new_id)
//  cfg       to block   i_cfg_we                     i_cfg_data (cells_in_use)
//
// One item at a time. Allocate and erase send a token up the whole chain, one cell
// per cycle, and a successful allocate then takes a mark step before the result.
// Defragment runs odd-even neighbour swaps, one round per cycle.
// Rejected requests (zero or oversize size, ids used up, id zero) skip the scan.
// Synchronous reset frees every cell and clears the id counter; no clearing pass.
// A stalled result holds the block in its result state until taken.
module first_fit_cell_allocator import ffca_pkg::*; #(
    parameter int CELLS   = CELLS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data
);

    localparam logic [CNT_W-1:0] CELLS_N = (CELLS > MAX_N) ? CNT_W'(MAX_N) : CNT_W'(CELLS);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cfg;
    logic [1:0]         r_op;
    logic [SIZE_W-1:0]  r_size;
    logic [EID_W-1:0]   r_id;
    logic [CNT_W-1:0]   r_n;
    logic [ID_BITS-1:0] r_last_id;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_phase;
    logic [CNT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_hi;
    t_status            r_status;
    logic [EID_W-1:0]   r_new_id;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [CNT_W-1:0]   n_cfg;
    logic               alloc_null;
    logic               scan_done;
    logic               inject;
    logic               out_load;
    logic               accept;
    t_cell_cmd          cmd;
    t_tok               tok [CELLS+1];
    logic [ID_BITS-1:0] owner [CELLS];

    assign n_cfg      = (r_cfg > CELLS_N) ? CELLS_N : r_cfg;
    assign alloc_null = (r_size == '0) || (r_size > {1'b0, r_n}) || (r_last_id == '1);
    assign scan_done  = tok[CELLS].valid;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_START;
            end
            S_START: begin
                priority if (r_op == OP_ALLOC) begin
                    n_state = alloc_null ? S_RESULT : S_SCAN;
                end else if (r_op == OP_ERASE) begin
                    n_state = (r_id == '0) ? S_RESULT : S_SCAN;
                end else begin
                    n_state = S_SWAP;
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = ((r_op == OP_ALLOC) && tok[CELLS].found) ? S_MARK : S_RESULT;
                end
            end
            S_MARK: n_state = S_RESULT;
            S_SWAP: begin
                if (r_cnt == r_n) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = CO_NONE;
        cmd.size     = r_size;
        cmd.erase_id = r_id;
        cmd.n        = r_n;
        cmd.mark_lo  = r_lo;
        cmd.mark_hi  = r_hi;
        cmd.phase    = r_phase;
        o_in_stall   = 1'b1;
        inject       = 1'b0;
        out_load     = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_START, S_SCAN: begin
                priority if (r_op == OP_ALLOC) cmd.op = CO_ALLOC;
                else if (r_op == OP_ERASE) cmd.op = CO_ERASE;
                else cmd.op = CO_NONE;
                inject = (r_state == S_START) && (n_state == S_SCAN);
            end
            S_MARK: cmd.op = CO_MARK;
            S_SWAP: cmd.op = CO_SWAP;
            S_RESULT: out_load = !r_out_valid || !i_out_stall;
            default: begin
            end
        endcase
    end

    assign tok[0] = '{valid: inject, default: '0};

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [ID_BITS-1:0] lo_w;
        logic [ID_BITS-1:0] hi_w;
        if (g == 0) begin : g_lo0
            assign lo_w = '0;
        end else begin : g_lo
            assign lo_w = owner[g-1];
        end
        if (g == CELLS - 1) begin : g_hi0
            assign hi_w = '0;
        end else begin : g_hi
            assign hi_w = owner[g+1];
        end
        ffca_cell #(
            .CELL_IDX (g),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_mark_id  (r_last_id),
            .i_tok      (tok[g]),
            .i_lo_owner (lo_w),
            .i_hi_owner (hi_w),
            .o_tok      (tok[g+1]),
            .o_owner    (owner[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_last_id   <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if ((r_state == S_SCAN) && scan_done && (r_op == OP_ALLOC)
                    && tok[CELLS].found) begin
                r_last_id <= r_last_id + ID_BITS'(1);
            end
            if (r_state == S_START) begin
                r_cnt   <= '0;
                r_phase <= 1'b0;
            end else if (r_state == S_SWAP) begin
                r_cnt   <= r_cnt + CNT_W'(1);
                r_phase <= !r_phase;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in.op;
            r_size <= i_in.alloc_size;
            r_id   <= i_in.erase_id;
            r_n    <= n_cfg;
        end
        if (r_state == S_START) begin
            r_new_id <= '0;
            priority if (r_op == OP_ALLOC) r_status <= ST_NULL;
            else if (r_op == OP_ERASE) r_status <= ST_ILLEGAL;
            else r_status <= ST_DEFRAG;
        end
        if ((r_state == S_SCAN) && scan_done) begin
            if (r_op == OP_ALLOC) begin
                if (tok[CELLS].found) begin
                    r_status <= ST_ALLOC;
                    r_new_id <= EID_W'(r_last_id + ID_BITS'(1));
                    r_lo     <= tok[CELLS].end_idx - r_size[CNT_W-1:0] + CNT_W'(1);
                    r_hi     <= tok[CELLS].end_idx;
                end else begin
                    r_status <= ST_NULL;
                end
            end else begin
                r_status <= tok[CELLS].hit ? ST_ERASED : ST_ILLEGAL;
            end
        end
        if (out_load) begin
            r_out.status <= r_status;
            r_out.new_id <= r_new_id;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
